// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, evaluated through reset as well.
`define ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/wsm_pkg.sv =====
package wsm_pkg;

  localparam int ScoreW   = 32;
  localparam int SumW     = 40;
  localparam int CntW     = 8;
  localparam int DivStep  = 4;
  localparam int DivIters = SumW / DivStep;
  localparam int IterW    = $clog2(DivIters);
  localparam int QDepth   = 2;

  localparam logic [CntW-1:0] WindowReset = 8'd16;

  // one division job handed from front to back
  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [CntW-1:0] units;
  } wsm_job_t;

  // queue side status
  typedef struct packed {
    logic full;
    logic avail;
  } wsm_qstat_t;

endpackage

// ===== rtl/wsm_front.sv =====
module wsm_front #(
  parameter int MAX_UNITS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [wsm_pkg::CntW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [wsm_pkg::ScoreW-1:0] in_score_i,
  input  logic                     in_restart_i,
  output logic                     push_o,
  output wsm_pkg::wsm_job_t        push_job_o,
  input  wsm_pkg::wsm_qstat_t      qstat_i
);
  import wsm_pkg::*;

  localparam int IdxW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam logic [CntW-1:0] MaxN = CntW'(MAX_UNITS);

  typedef enum logic {F_IDLE, F_UPD} state_e;

  state_e            state_q;
  logic [CntW-1:0]   window_q, fill_q, oldest_q;
  logic [SumW-1:0]   sum_q;
  logic [ScoreW-1:0] score_q, rd_q;
  logic [ScoreW-1:0] ring [MAX_UNITS];

  logic [CntW-1:0]   units, fill_eff, fill_inc, oldest_inc, oldest_nxt;
  logic [SumW-1:0]   sum_base, sum_fill, sum_slide;
  logic              accept, do_fill, wr_en;
  logic [IdxW-1:0]   wr_addr;
  logic [ScoreW-1:0] wr_data;

  // clamp window size to 1..MAX_UNITS
  always_comb begin
    if (window_q == '0) begin
      units = CntW'(1);
    end else if (window_q > MaxN) begin
      units = MaxN;
    end else begin
      units = window_q;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == F_IDLE) && !qstat_i.full;
  assign accept      = in_valid_i && in_ready_o;

  assign fill_eff   = in_restart_i ? '0 : fill_q;
  assign sum_base   = in_restart_i ? '0 : sum_q;
  assign do_fill    = fill_eff < units;
  assign fill_inc   = fill_eff + CntW'(1);
  assign sum_fill   = sum_base + SumW'(in_score_i);
  assign sum_slide  = sum_q - SumW'(rd_q) + SumW'(score_q);
  assign oldest_inc = oldest_q + CntW'(1);
  assign oldest_nxt = (oldest_inc >= units) ? '0 : oldest_inc;

  assign wr_en   = (accept && do_fill) || (state_q == F_UPD);
  assign wr_addr = (state_q == F_UPD) ? oldest_q[IdxW-1:0] : fill_eff[IdxW-1:0];
  assign wr_data = (state_q == F_UPD) ? score_q : in_score_i;

  assign push_o           = (accept && do_fill && (fill_inc == units)) || (state_q == F_UPD);
  assign push_job_o.sum   = (state_q == F_UPD) ? sum_slide : sum_fill;
  assign push_job_o.units = units;

  // ring: one write port, registered read of the oldest slot
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring[wr_addr] <= wr_data;
    end
    rd_q <= ring[oldest_q[IdxW-1:0]];
    if (accept) begin
      score_q <= in_score_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      window_q <= WindowReset;
      fill_q   <= '0;
      oldest_q <= '0;
      sum_q    <= '0;
    end else if (cfg_valid_i) begin
      window_q <= cfg_data_i;
      fill_q   <= '0;
      oldest_q <= '0;
      sum_q    <= '0;
      state_q  <= F_IDLE;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept) begin
            if (do_fill) begin
              sum_q  <= sum_fill;
              fill_q <= fill_inc;
              if (fill_inc == units) begin
                oldest_q <= '0;
              end
            end else begin
              state_q <= F_UPD;
            end
          end
        end
        F_UPD: begin
          sum_q    <= sum_slide;
          oldest_q <= oldest_nxt;
          state_q  <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/wsm_queue.sv =====
module wsm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  wsm_pkg::wsm_job_t   job_i,
  output wsm_pkg::wsm_qstat_t qstat_o,
  input  logic                pop_i,
  output wsm_pkg::wsm_job_t   job_o
);
  import wsm_pkg::*;

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntQW = $clog2(QDepth + 1);

  wsm_job_t         mem_q [QDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntQW-1:0] count_q;
  logic             do_push, do_pop;

  assign qstat_o.full  = (count_q == CntQW'(QDepth));
  assign qstat_o.avail = (count_q != '0);
  assign job_o         = mem_q[rd_ptr_q];
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && qstat_o.avail;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= PtrW'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= PtrW'(rd_ptr_q + 1'b1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CntQW'(1);
        2'b01:   count_q <= count_q - CntQW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== rtl/wsm_back.sv =====
module wsm_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wsm_pkg::wsm_qstat_t        qstat_i,
  input  wsm_pkg::wsm_job_t          job_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [wsm_pkg::ScoreW-1:0] out_data_o
);
  import wsm_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_RUN, B_DONE} state_e;

  state_e            state_q;
  logic [SumW-1:0]   dvd_q, dvd_nxt;
  logic [CntW-1:0]   rem_q, rem_nxt, div_q;
  logic [IterW-1:0]  iter_q;
  logic              out_valid_q;
  logic [ScoreW-1:0] out_data_q;
  logic [CntW:0]     trial;
  logic              load_out;

  // restoring division, DivStep quotient bits per cycle; quotient shifts into dvd
  always_comb begin
    dvd_nxt = dvd_q;
    rem_nxt = rem_q;
    trial   = '0;
    for (int i = 0; i < DivStep; i++) begin
      trial   = {rem_nxt, dvd_nxt[SumW-1]};
      dvd_nxt = {dvd_nxt[SumW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_nxt    = CntW'(trial - {1'b0, div_q});
        dvd_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[CntW-1:0];
      end
    end
  end

  assign pop_o       = qstat_i.avail && (state_q == B_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  // quotient moves to the output register once that register is free
  assign load_out    = (state_q == B_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      dvd_q       <= '0;
      rem_q       <= '0;
      div_q       <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            dvd_q   <= job_i.sum;
            div_q   <= job_i.units;
            rem_q   <= '0;
            iter_q  <= '0;
            state_q <= B_RUN;
          end
        end
        B_RUN: begin
          dvd_q  <= dvd_nxt;
          rem_q  <= rem_nxt;
          iter_q <= iter_q + IterW'(1);
          if (iter_q == IterW'(DivIters - 1)) begin
            state_q <= B_DONE;
          end
        end
        B_DONE: begin
          if (load_out) begin
            out_data_q <= dvd_q[ScoreW-1:0];
            state_q    <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/window_score_mean.sv =====
// Sliding-window mean of unit scores. Each input word carries one score and a
// restart flag; the block keeps the last N scores (N = window register clamped
// to 1..MAX_UNITS) in a ring and their 40-bit running sum. While a window is
// filling, a word is stored and gives no result; the word that completes the
// fill and every later one give floor(sum / N). A sliding word ends in F_UPD,
// which uses the ring's registered read of the oldest slot and takes no new
// word. Sums go through a two-entry queue to a restoring divider that retires
// four quotient bits a cycle. A result passes through pop, ten divide steps
// and hand-off to the output register; the next sum is popped only after that
// hand-off, and the queue plus output register absorb short bursts. Restart
// drops the held scores and begins a new fill at slot 0. A write to the window
// register always empties the window; it is taken in any cycle and should
// only be issued while the block is idle.
module window_score_mean #(
  parameter int MAX_UNITS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input words
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [wsm_pkg::ScoreW-1:0] s_axis_tdata,  // [31:0] unit_score
  input  logic                       s_axis_tuser,  // [0] restart
  // result words
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [wsm_pkg::ScoreW-1:0] m_axis_tdata,  // [31:0] mean_score
  // window size register
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [wsm_pkg::CntW-1:0]   cfg_data_i
);
  import wsm_pkg::*;

  logic       push, pop;
  wsm_job_t   push_job, pop_job;
  wsm_qstat_t qstat;

  // front: ring, running sum, fill tracking
  wsm_front #(
    .MAX_UNITS(MAX_UNITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_score_i  (s_axis_tdata),
    .in_restart_i(s_axis_tuser),
    .push_o      (push),
    .push_job_o  (push_job),
    .qstat_i     (qstat)
  );

  // decouples sum update from the divider
  wsm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .qstat_o(qstat),
    .pop_i  (pop),
    .job_o  (pop_job)
  );

  // back: divider and output register
  wsm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .qstat_i    (qstat),
    .job_i      (pop_job),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule

// ===== rtl/wsm_checker.sv =====
`include "assert_macros.svh"

module wsm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [wsm_pkg::ScoreW-1:0] m_axis_tdata,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_o
);
  import wsm_pkg::*;

  // a stalled result word keeps its valid and its data
  `ASSERT_IMPLY(a_out_hold, clk_i, rst_ni, $past(m_axis_tvalid && !m_axis_tready), m_axis_tvalid && $stable(m_axis_tdata), "stalled result word changed")

  // window register writes are never back-pressured
  `ASSERT_IMPLY(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o, "config write stalled")

  // reset leaves no result pending
  `ASSERT_NEXT(a_rst_empty, clk_i, !rst_ni, !m_axis_tvalid, "result valid out of reset")

endmodule

bind window_score_mean wsm_checker u_wsm_checker (.*);

// ===== tb/window_score_mean_test.sv =====
`timescale 1ns / 1ps

module window_score_mean_test;

  localparam int MaxUnits = 64;
  localparam int ItemTarget = 1650;
  // Hold-off that covers the back end, the queue and the output register.
  localparam int SettleCycles = 40;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [wsm_pkg::ScoreW-1:0] s_axis_tdata;  // [31:0] unit_score
  logic s_axis_tuser;                        // [0] restart
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [wsm_pkg::ScoreW-1:0] m_axis_tdata;  // [31:0] mean_score
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [wsm_pkg::CntW-1:0] cfg_data_i;

  window_score_mean #(
    .MAX_UNITS(MaxUnits)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i
  );

  // Shadow copy of the window: ring, 40-bit sum, oldest slot, fill level, register.
  logic [31:0] shadow_ring [MaxUnits];
  logic [39:0] shadow_sum;
  int unsigned shadow_oldest;
  int unsigned shadow_fill;
  logic [7:0] shadow_window;

  logic [31:0] pending_means [$];  // means still owed by the block, oldest first
  logic [31:0] owed_mean;
  int mismatch_count;
  int items_sent;
  bit steady;  // no idling on either side while set

  // Directed vectors. typed rows carry a mean readable by hand; every mean of
  // such a row must equal it. Other rows are checked against the shadow window.
  typedef struct packed {
    bit wr_window;
    logic [7:0] window;
    logic [31:0] score;
    bit restart;
    int reps;
    bit typed;
    logic [31:0] mean;
  } vec_t;

  vec_t directed_vecs [16] = '{
    // reset window (16): fill with max scores, mean of a full max window is max
    '{1'b0, 8'd0,   32'hFFFF_FFFF, 1'b0, 15, 1'b0, 32'h0},
    '{1'b0, 8'd0,   32'hFFFF_FFFF, 1'b0, 1,  1'b1, 32'hFFFF_FFFF},
    '{1'b0, 8'd0,   32'h0000_0000, 1'b0, 1,  1'b0, 32'h0},
    // restart on a full 16-wide window: back to filling, no word out
    '{1'b0, 8'd0,   32'h0000_0000, 1'b1, 1,  1'b0, 32'h0},
    // window of one: every score is its own mean, restart included
    '{1'b1, 8'd1,   32'h0000_0000, 1'b0, 1,  1'b1, 32'h0000_0000},
    '{1'b0, 8'd0,   32'hFFFF_FFFF, 1'b0, 1,  1'b1, 32'hFFFF_FFFF},
    '{1'b0, 8'd0,   32'h5555_5555, 1'b1, 1,  1'b1, 32'h5555_5555},
    '{1'b0, 8'd0,   32'hAAAA_AAAA, 1'b0, 1,  1'b1, 32'hAAAA_AAAA},
    // register max clamps to MAX_UNITS; widest sum, then flush the ring with zeros
    '{1'b1, 8'd255, 32'hFFFF_FFFF, 1'b0, 64, 1'b1, 32'hFFFF_FFFF},
    '{1'b0, 8'd0,   32'h0000_0000, 1'b0, 64, 1'b0, 32'h0},
    // window of two: truncation, restart mid-stream
    '{1'b1, 8'd2,   32'h0000_0007, 1'b0, 1,  1'b0, 32'h0},
    '{1'b0, 8'd0,   32'h0000_0008, 1'b0, 1,  1'b1, 32'h0000_0007},
    '{1'b0, 8'd0,   32'h0000_0001, 1'b1, 1,  1'b0, 32'h0},
    '{1'b0, 8'd0,   32'h0000_0003, 1'b0, 1,  1'b1, 32'h0000_0002},
    // full-size window, slides past the ring wrap
    '{1'b1, 8'd64,  32'h1234_5678, 1'b0, 70, 1'b0, 32'h0},
    // rewrite of the same value still empties the window
    '{1'b1, 8'd64,  32'h0000_0001, 1'b0, 3,  1'b0, 32'h0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int unsigned units_in_use();
    int unsigned n;
    n = shadow_window;
    if (n < 1) n = 1;
    if (n > MaxUnits) n = MaxUnits;
    return n;
  endfunction

  // Advance the shadow window by one score; returns 1 when a mean comes out.
  function automatic bit slide_window(input logic [31:0] score, input bit restart,
                                      output logic [31:0] mean);
    int unsigned n;
    int unsigned slot;
    n = units_in_use();
    mean = '0;
    if (restart) begin
      shadow_sum = '0;
      shadow_oldest = 0;
      shadow_fill = 0;
    end
    if (shadow_fill < n) begin
      shadow_ring[shadow_fill % MaxUnits] = score;
      shadow_sum = shadow_sum + 40'(score);
      shadow_fill++;
      if (shadow_fill < n) return 1'b0;
      shadow_oldest = 0;
    end else begin
      slot = shadow_oldest % MaxUnits;
      shadow_sum = shadow_sum - 40'(shadow_ring[slot]) + 40'(score);
      shadow_ring[slot] = score;
      shadow_oldest = (slot + 1 >= n) ? 0 : slot + 1;
    end
    mean = 32'(shadow_sum / 40'(n));
    return 1'b1;
  endfunction

  function automatic logic [31:0] pick_score();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(255));
      default: return 32'($urandom());
    endcase
  endfunction

  // Drop tvalid and wait until every owed mean has been taken.
  task automatic drain_means();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_means.size() != 0);
  endtask

  // Register write only with the block idle; the hold-off adds settle time after
  // the last owed mean has been taken.
  task automatic write_window(input logic [7:0] value);
    drain_means();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shadow_window = value;
    shadow_sum = '0;
    shadow_oldest = 0;
    shadow_fill = 0;
  endtask

  task automatic send_word(input logic [31:0] score, input bit restart,
                           input bit typed, input logic [31:0] typed_mean);
    logic [31:0] mean;
    while (!steady && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= score;
    s_axis_tuser <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
    if (slide_window(score, restart, mean)) pending_means.push_back(typed ? typed_mean : mean);
    items_sent++;
  endtask

  // Result side: random backpressure except in steady stretches.
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 23);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_means.size() == 0) begin
        $error("mean_score: no word expected, got %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        owed_mean = pending_means.pop_front();
        if (m_axis_tdata !== owed_mean) begin
          $error("mean_score: expected %h, got %h", owed_mean, m_axis_tdata);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int phase;
    int count;
    int r;
    int unsigned n;
    logic [7:0] window;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    mismatch_count = 0;
    items_sent = 0;
    steady = 1'b0;
    shadow_window = wsm_pkg::WindowReset;
    shadow_sum = '0;
    shadow_oldest = 0;
    shadow_fill = 0;
    foreach (shadow_ring[i]) shadow_ring[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_vecs[v]) begin
      if (directed_vecs[v].wr_window) write_window(directed_vecs[v].window);
      repeat (directed_vecs[v].reps)
        send_word(directed_vecs[v].score, directed_vecs[v].restart,
                  directed_vecs[v].typed, directed_vecs[v].mean);
    end

    // Random phases: a fresh window size each, mostly small so means come often.
    phase = 0;
    while (items_sent < ItemTarget) begin
      r = $urandom_range(99);
      if (r < 45) window = 8'($urandom_range(1, 4));
      else if (r < 70) window = 8'($urandom_range(5, 16));
      else if (r < 80) window = 8'(MaxUnits);
      else if (r < 85) window = 8'd255;
      else if (r < 90) window = 8'($urandom_range(MaxUnits + 1, 254));
      else window = 8'($urandom_range(17, MaxUnits - 1));
      write_window(window);
      steady = (phase == 3);
      n = units_in_use();
      count = (n > 16) ? n + $urandom_range(20, 80) : $urandom_range(20, 60);
      for (int k = 0; k < count; k++) begin
        // one mid-stream pause until the block has caught up
        if (phase == 6 && k == count / 2) drain_means();
        send_word(pick_score(), $urandom_range(99) < 4, 1'b0, '0);
      end
      steady = 1'b0;
      phase++;
    end

    drain_means();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
